// ===== hw/rtl/utcgps_pkg.sv =====
package utcgps_pkg;

  localparam int YEAR_SPAN  = 128;
  localparam int EPOCH_YEAR = 1980;

  localparam int YO_W  = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
  localparam int DAY_W = $clog2(YEAR_SPAN * 366 + 368);
  localparam int DIV_S = DAY_W + 3;
  localparam int DIV_M_W = DIV_S - 2;
  localparam logic [DIV_M_W-1:0] DIV7_M = DIV_M_W'((64'd1 << DIV_S) / 64'd7);
  localparam int QW = DAY_W - 2;

  localparam logic [41:0] MS_PER_WEEK = 42'd604800000;
  localparam logic [41:0] UNIX_OFFSET_MS = 42'd3657 * 42'd86400000;

  typedef logic [DAY_W-1:0] ydays_tab_t [YEAR_SPAN];
  typedef logic [29:0] wday_tab_t [8];

  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam wday_tab_t WDAY_MS = '{
    30'd0, 30'd86400000, 30'd172800000, 30'd259200000,
    30'd345600000, 30'd432000000, 30'd518400000, 30'd0
  };

  function automatic bit is_leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic ydays_tab_t build_ydays();
    ydays_tab_t tab;
    int acc;
    acc = 0;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      tab[i] = DAY_W'(acc);
      acc += is_leap_year(EPOCH_YEAR + i) ? 366 : 365;
    end
    return tab;
  endfunction

  function automatic logic [YEAR_SPAN-1:0] build_leap();
    logic [YEAR_SPAN-1:0] v;
    v = '0;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      v[i] = is_leap_year(EPOCH_YEAR + i);
    end
    return v;
  endfunction

  localparam ydays_tab_t YEAR_START_DAYS = build_ydays();
  localparam logic [YEAR_SPAN-1:0] LEAP_YEARS = build_leap();

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } tod_t;

endpackage

// ===== hw/rtl/utc_to_gps_week_time.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    year, month, day_of_month, hour, minute,
//                                            second, millisecond
// out      output     out_valid / out_ready  gps_week, week_time_ms, unix_time_ms,
//                                            before_epoch
// cfg      input      cfg_valid / cfg_ready  leap_seconds
//
// Three register stages (input, day count, result); one item per cycle while out_ready is high.
// The day count is cut from the week split at the divide-by-seven reciprocal multiply.
// Reset (rst_n low, synchronous) empties all stages and clears leap_seconds.
// A stalled result holds in the output stage; earlier stages fill behind it until all are full.
// cfg_ready is always high.
module utc_to_gps_week_time
  import utcgps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day_of_month,
  input  logic [4:0]  in_hour,
  input  logic [5:0]  in_minute,
  input  logic [5:0]  in_second,
  input  logic [9:0]  in_millisecond,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_gps_week,
  output logic [29:0] out_week_time_ms,
  output logic [41:0] out_unix_time_ms,
  output logic        out_before_epoch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_leap_seconds
);

  logic [5:0] leap_r;

  logic        v0_r, v1_r, v2_r;
  logic        ld0, ld1, ld2;

  logic [11:0] year0_r;
  logic [3:0]  month0_r;
  logic [4:0]  day0_r;
  tod_t        tod0_r;

  logic              before1_r;
  logic [DAY_W-1:0]  t1_r;
  logic [QW-1:0]     qe1_r;
  tod_t              tod1_r;

  logic        yr_lo, yr_hi;
  logic [11:0] ydiff;
  logic [YO_W-1:0] yidx;
  logic [3:0]  midx;
  logic        leap_add;
  logic [DAY_W-1:0] total, t_nxt;
  logic [DAY_W+DIV_M_W-1:0] prod;
  logic        before_nxt;

  logic [DAY_W-1:0] rem_full;
  logic [QW-1:0]    week;
  logic [2:0]       rem;
  logic [29:0]      wtime;
  logic [41:0]      utime;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= '0;
    end else if (cfg_valid) begin
      leap_r <= cfg_leap_seconds;
    end
  end

  assign ld2      = !v2_r || out_ready;
  assign ld1      = !v1_r || ld2;
  assign ld0      = !v0_r || ld1;
  assign in_ready = ld0;

  always_comb begin
    yr_lo = year0_r < 12'(EPOCH_YEAR);
    yr_hi = year0_r >= 12'(EPOCH_YEAR + YEAR_SPAN);
    ydiff = year0_r - 12'(EPOCH_YEAR);
    priority if (yr_hi) begin
      yidx = YO_W'(YEAR_SPAN - 1);
    end else if (yr_lo) begin
      yidx = '0;
    end else begin
      yidx = ydiff[YO_W-1:0];
    end
    priority if (month0_r == 4'd0) begin
      midx = 4'd0;
    end else if (month0_r > 4'd12) begin
      midx = 4'd11;
    end else begin
      midx = month0_r - 4'd1;
    end
    leap_add = (midx >= 4'd2) && LEAP_YEARS[yidx];
    total = YEAR_START_DAYS[yidx] + DAY_W'(MONTH_START[midx]) + DAY_W'(leap_add)
          + DAY_W'(day0_r);
    before_nxt = yr_lo || (total < DAY_W'(6));
    t_nxt = total - DAY_W'(6);
    prod  = (DAY_W + DIV_M_W)'(t_nxt) * (DAY_W + DIV_M_W)'(DIV7_M);
  end

  always_comb begin
    rem_full = t1_r - DAY_W'(qe1_r) * DAY_W'(7);
    if (rem_full >= DAY_W'(7)) begin
      week = qe1_r + QW'(1);
      rem  = 3'(rem_full - DAY_W'(7));
    end else begin
      week = qe1_r;
      rem  = 3'(rem_full);
    end
    wtime = WDAY_MS[rem]
          + 30'(tod1_r.hour) * 30'd3600000
          + 30'(tod1_r.minute) * 30'd60000
          + 30'(tod1_r.second) * 30'd1000
          + 30'(tod1_r.millisecond)
          + 30'(leap_r) * 30'd1000;
    utime = 42'(week) * MS_PER_WEEK + 42'(wtime) + UNIX_OFFSET_MS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (ld0) v0_r <= in_valid;
      if (ld1) v1_r <= v0_r;
      if (ld2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      year0_r            <= in_year;
      month0_r           <= in_month;
      day0_r             <= in_day_of_month;
      tod0_r.hour        <= in_hour;
      tod0_r.minute      <= in_minute;
      tod0_r.second      <= in_second;
      tod0_r.millisecond <= in_millisecond;
    end
    if (ld1) begin
      before1_r <= before_nxt;
      t1_r      <= t_nxt;
      qe1_r     <= prod[DIV_S +: QW];
      tod1_r    <= tod0_r;
    end
    if (ld2) begin
      out_before_epoch <= before1_r;
      out_gps_week     <= before1_r ? '0 : 13'(week);
      out_week_time_ms <= before1_r ? '0 : wtime;
      out_unix_time_ms <= before1_r ? '0 : utime;
    end
  end

  assign out_valid = v2_r;

  a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_before_epoch) |->
      (out_gps_week == '0 && out_week_time_ms == '0 && out_unix_time_ms == '0))
    else $error("before-epoch result carries nonzero fields");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !before1_r) |-> (rem_full < DAY_W'(14)))
    else $error("week split estimate off by more than one");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v0_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import utcgps_pkg::*;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  msec;
  } utc_stamp_t;

  typedef struct packed {
    logic [12:0] week;
    logic [29:0] wtime;
    logic [41:0] utime;
    logic        pre_epoch;
  } gps_time_t;

  localparam longint unsigned MS_DAY = 64'd86400000;
  localparam int MONTH_OFFSET [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_year = '0;
  logic [3:0]  in_month = '0;
  logic [4:0]  in_day_of_month = '0;
  logic [4:0]  in_hour = '0;
  logic [5:0]  in_minute = '0;
  logic [5:0]  in_second = '0;
  logic [9:0]  in_millisecond = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] out_gps_week;
  logic [29:0] out_week_time_ms;
  logic [41:0] out_unix_time_ms;
  logic        out_before_epoch;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_leap_seconds = '0;

  gps_time_t   gps_due[$];
  logic [5:0]  leap_offset_s = '0;
  int          mismatches = 0;
  int          send_idle_pct = 28;
  int          recv_idle_pct = 28;
  int          hold_left = 0;

  utc_to_gps_week_time u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day_of_month  (in_day_of_month),
    .in_hour          (in_hour),
    .in_minute        (in_minute),
    .in_second        (in_second),
    .in_millisecond   (in_millisecond),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_gps_week     (out_gps_week),
    .out_week_time_ms (out_week_time_ms),
    .out_unix_time_ms (out_unix_time_ms),
    .out_before_epoch (out_before_epoch),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_leap_seconds (cfg_leap_seconds)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit is_greg_leap(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned leap_days_to(longint unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic gps_time_t utc_to_gps(utc_stamp_t s, logic [5:0] leap);
    gps_time_t r;
    longint unsigned y, mo, days, wt, ut;
    r = '0;
    if (s.year < EPOCH_YEAR) begin
      r.pre_epoch = 1'b1;
      return r;
    end
    y = (s.year > EPOCH_YEAR + YEAR_SPAN - 1) ? EPOCH_YEAR + YEAR_SPAN - 1 : s.year;
    mo = (s.month == 0) ? 1 : (s.month > 12) ? 12 : s.month;
    days = 365 * (y - EPOCH_YEAR) + leap_days_to(y - 1) - leap_days_to(EPOCH_YEAR - 1)
         + MONTH_OFFSET[mo - 1] + s.day;
    if (mo > 2 && is_greg_leap(y)) begin
      days++;
    end
    if (days < 6) begin
      r.pre_epoch = 1'b1;
      return r;
    end
    days -= 6;
    wt = (days % 7) * MS_DAY + s.hour * 64'd3600000 + s.minute * 64'd60000
       + s.second * 64'd1000 + s.msec + leap * 64'd1000;
    ut = (days / 7) * 7 * MS_DAY + wt + 64'd3657 * MS_DAY;
    r.week  = 13'(days / 7);
    r.wtime = 30'(wt);
    r.utime = 42'(ut);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  // hold the result channel off while a test asks for it
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    gps_time_t want;
    if (out_valid && out_ready) begin
      if (gps_due.size() == 0) begin
        flag_mismatch("result with no item pending");
      end else begin
        want = gps_due.pop_front();
        if (out_gps_week !== want.week)
          flag_mismatch($sformatf("gps_week %0d, want %0d", out_gps_week, want.week));
        if (out_week_time_ms !== want.wtime)
          flag_mismatch($sformatf("week_time_ms %0d, want %0d", out_week_time_ms, want.wtime));
        if (out_unix_time_ms !== want.utime)
          flag_mismatch($sformatf("unix_time_ms %0d, want %0d", out_unix_time_ms, want.utime));
        if (out_before_epoch !== want.pre_epoch)
          flag_mismatch($sformatf("before_epoch %0b, want %0b", out_before_epoch,
                                  want.pre_epoch));
      end
    end
  end

  task automatic send_stamp(input logic [11:0] y, input logic [3:0] mo, input logic [4:0] d,
                            input logic [4:0] h, input logic [5:0] mi, input logic [5:0] sec,
                            input logic [9:0] ms);
    utc_stamp_t s;
    s = '{y, mo, d, h, mi, sec, ms};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_year         <= y;
    in_month        <= mo;
    in_day_of_month <= d;
    in_hour         <= h;
    in_minute       <= mi;
    in_second       <= sec;
    in_millisecond  <= ms;
    do @(posedge clk); while (!in_ready);
    gps_due = {gps_due, utc_to_gps(s, leap_offset_s)};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (gps_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_leap(logic [5:0] v);
    drain_results();
    cfg_valid        <= 1'b1;
    cfg_leap_seconds <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    leap_offset_s = v;
  endtask

  task automatic send_random_stamps(int n);
    logic [11:0] y;
    logic [3:0]  mo;
    logic [4:0]  d, h;
    logic [5:0]  mi, sec;
    logic [9:0]  ms;
    int          kind, mdays;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      y    = 12'($urandom_range(2107, 1980));
      mo   = 4'($urandom_range(12, 1));
      h    = 5'($urandom_range(23, 0));
      mi   = 6'($urandom_range(59, 0));
      sec  = ($urandom_range(99) == 0) ? 6'd60 : 6'($urandom_range(59, 0));
      ms   = 10'($urandom_range(999, 0));
      mdays = (mo == 2) ? 28 + is_greg_leap(y) :
              (mo == 4 || mo == 6 || mo == 9 || mo == 11) ? 30 : 31;
      d    = 5'($urandom_range(mdays, 1));
      if (kind >= 86) begin
        {y, mo, d, h, mi, sec, ms} = 48'({$urandom, $urandom});
      end else if (kind >= 72) begin
        case ($urandom_range(2))
          0: begin
            y  = 12'($urandom_range(1981, 1978));
            mo = 4'($urandom_range(2, 0));
            d  = 5'($urandom_range(10, 0));
          end
          1: begin
            y  = 12'($urandom_range(2115, 2096));
            mo = 4'($urandom_range(15, 0));
            d  = 5'($urandom_range(31, 0));
          end
          default: begin
            h   = 5'($urandom);
            mi  = 6'($urandom);
            sec = 6'($urandom);
            ms  = 10'($urandom);
          end
        endcase
      end
      send_stamp(y, mo, d, h, mi, sec, ms);
    end
  endtask

  task automatic test_directed_dates();
    write_leap(6'd0);
    send_stamp(12'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd1980, 4'd1, 5'd5, 5'd23, 6'd59, 6'd59, 10'd999);
    send_stamp(12'd1979, 4'd12, 5'd31, 5'd12, 6'd30, 6'd30, 10'd500);
    send_stamp(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd1980, 4'd1, 5'd0, 5'd1, 6'd2, 6'd3, 10'd4);
    send_stamp(12'd1980, 4'd1, 5'd13, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd1980, 4'd1, 5'd12, 5'd23, 6'd59, 6'd60, 10'd999);
    send_stamp(12'd1980, 4'd2, 5'd29, 5'd6, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2000, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2100, 4'd2, 5'd28, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2004, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2006, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999);
    send_stamp(12'd2107, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999);
    send_stamp(12'd2108, 4'd6, 5'd15, 5'd8, 6'd15, 6'd45, 10'd250);
    send_stamp(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023);
    send_stamp(12'd2048, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2024, 4'd0, 5'd15, 5'd10, 6'd20, 6'd30, 10'd40);
    send_stamp(12'd2024, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2024, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2023, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2019, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0);
    send_stamp(12'd2010, 4'd7, 5'd4, 5'd31, 6'd63, 6'd63, 10'd1023);
  endtask

  task automatic test_leap_offsets();
    write_leap(6'd63);
    send_random_stamps(330);
    write_leap(6'd18);
    send_random_stamps(330);
    write_leap(6'($urandom_range(62, 1)));
    send_random_stamps(330);
    write_leap(6'd1);
    send_random_stamps(330);
  endtask

  task automatic test_output_backpressure();
    write_leap(6'd45);
    send_idle_pct = 0;
    hold_left = 80;
    send_random_stamps(40);
    send_idle_pct = 28;
  endtask

  task automatic test_full_rate();
    write_leap(6'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_stamps(300);
    send_idle_pct = 28;
    recv_idle_pct = 28;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_dates();
    test_leap_offsets();
    test_output_backpressure();
    test_full_rate();
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
